// ===== rtl/segam_pkg.sv =====
// Package for the segmentation argmax mask core: payload word types and fixed constants.
// Depends on nothing; imported by the top level.
`default_nettype none

package segam_pkg;

    // Field widths fixed by the external interface.
    localparam int SCORE_FIELD_BITS = 16;
    localparam int CLASS_FIELD_BITS = 8;
    localparam int CFG_BITS         = 9;

    // Reset value of the class count register.
    localparam logic [CFG_BITS-1:0] CLASS_COUNT_RESET = 9'd21;

    // Width of the frame epoch tag stored per class in the presence memory.
    localparam int EPOCH_BITS = 8;

    typedef struct packed {
        logic [SCORE_FIELD_BITS-1:0] score;
        logic                        frame_start;
    } in_word_t;

    typedef struct packed {
        logic [CLASS_FIELD_BITS-1:0] mask_class;
        logic                        first_seen;
    } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/segam_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; used by the segmentation argmax mask core.
`default_nettype none

module segam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/segmentation_argmax_mask_core.sv =====
// Top level of the segmentation argmax mask core: pixel accumulator, presence lookup, output.
// Depends on segam_pkg and segam_ram.
//
// Usage:
// The s_ channel takes one class score word per cycle, channel-interleaved: all scores
// of a pixel, class 0 first. frame_start on a word marks the first score of a frame;
// it restarts the pixel and forgets which classes have been seen. After the last
// channel of a pixel (set by the cfg_ write channel, the class count) one word leaves
// on the m_ channel with the winning class and a first-seen flag.
// Result path: a finished pixel waits in the pending lookup stage for its presence memory
// read, then moves into the output register, which drives the m_ channel.
// Throughput: one score word per cycle, sustained, as long as m_ready stays high.
// The presence memory read/modify/write per pixel is the pacing element; a pixel that
// ends right after another with the same class is served by forwarding.
// Stall: the output register and one pending lookup stage can each hold a pixel, so
// s_ready only drops while both are full and m_ready is low.
// Reset: aresetn (synchronous, active low) empties the pipeline, restarts the pixel,
// restores the class count to 21 and clears the presence valid bits; no
// clearing pass is needed. cfg_ready is always high.
`default_nettype none

module segmentation_argmax_mask_core
    import segam_pkg::*;
#(
    parameter int MAX_CLASSES = 256,
    parameter int SCORE_BITS  = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Score input channel.
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire in_word_t            s_data,
    // Result channel.
    output logic                     m_valid,
    input  wire logic                m_ready,
    output out_word_t                m_data,
    // Configuration write channel (class count).
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_BITS-1:0] cfg_data
);

    // Class index width is set by the number of classes the presence memory holds.
    localparam int CLS_BITS = $clog2(MAX_CLASSES);
    // Scores compare after masking to SCORE_BITS, never wider than the field.
    localparam int CMP_BITS = (SCORE_BITS < SCORE_FIELD_BITS) ? SCORE_BITS : SCORE_FIELD_BITS;
    localparam logic [CFG_BITS-1:0]   MAX_N      = CFG_BITS'(MAX_CLASSES);
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = {EPOCH_BITS{1'b1}};

    // Configuration register.
    logic [CFG_BITS-1:0] class_count_reg;
    logic [CFG_BITS-1:0] eff_classes;

    // Pixel accumulator.
    logic [CLS_BITS-1:0] count_reg,  count_next;
    logic [CMP_BITS-1:0] best_reg,   best_next;
    logic [CLS_BITS-1:0] bcls_reg,   bcls_next;

    // Frame epoch; the presence memory tags each class with the epoch it was seen in.
    logic [EPOCH_BITS-1:0] epoch_reg;
    logic [EPOCH_BITS-1:0] epoch_item;
    logic                  epoch_wrap;

    // Per-class valid bits qualify the epoch tags; they clear at reset and epoch wrap.
    logic [MAX_CLASSES-1:0] seen_valid_reg;

    // Pending lookup stage: holds a finished pixel while its memory read returns.
    logic                  p_valid_reg;
    logic [CLS_BITS-1:0]   p_cls_reg;
    logic [EPOCH_BITS-1:0] p_epoch_reg;
    logic                  p_fwd_reg;

    // Output register.
    logic      out_valid_reg;
    out_word_t out_word_reg;

    logic                  accept;
    logic                  p_move;
    logic                  pixel_last;
    logic [CLS_BITS-1:0]   count_cur;
    logic [CMP_BITS-1:0]   best_cur;
    logic [CLS_BITS-1:0]   bcls_cur;
    logic [CMP_BITS-1:0]   score_val;
    logic                  score_gt;
    logic [CMP_BITS-1:0]   best_new;
    logic [CLS_BITS-1:0]   bcls_new;
    logic                  fwd_hit;
    logic                  mem_we;
    logic [EPOCH_BITS-1:0] mem_rdata;
    logic                  p_seen;
    logic                  p_flag;

    assign cfg_ready = 1'b1;

    // A zero class count behaves as one; anything above the memory depth saturates.
    always_comb begin
        if (class_count_reg == '0) begin
            eff_classes = CFG_BITS'(1);
        end else if (class_count_reg > MAX_N) begin
            eff_classes = MAX_N;
        end else begin
            eff_classes = class_count_reg;
        end
    end

    // The pending stage empties into the output register whenever that register is
    // free or being drained. A new word can enter whenever the pending stage will be
    // free at the next edge.
    assign p_move  = p_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !p_valid_reg || p_move;
    assign accept  = s_valid && s_ready;

    // A frame start restarts the pixel before this word's score is considered.
    assign count_cur = s_data.frame_start ? '0 : count_reg;
    assign best_cur  = s_data.frame_start ? '0 : best_reg;
    assign bcls_cur  = s_data.frame_start ? '0 : bcls_reg;

    // Strictly greater replaces, so ties keep the lower class index.
    assign score_val = s_data.score[CMP_BITS-1:0];
    assign score_gt  = score_val > best_cur;
    assign best_new  = score_gt ? score_val : best_cur;
    assign bcls_new  = score_gt ? count_cur : bcls_cur;

    // The pixel ends once the count reaches or passes the last channel, which also
    // covers a class count lowered in mid-pixel.
    assign pixel_last = (CFG_BITS'(count_cur) + CFG_BITS'(1)) >= eff_classes;

    assign epoch_item = s_data.frame_start ? epoch_reg + EPOCH_BITS'(1) : epoch_reg;
    assign epoch_wrap = accept && s_data.frame_start && (epoch_reg == EPOCH_LAST);

    always_comb begin
        count_next = count_reg;
        best_next  = best_reg;
        bcls_next  = bcls_reg;
        if (accept) begin
            if (pixel_last) begin
                count_next = '0;
                best_next  = '0;
                bcls_next  = '0;
            end else begin
                count_next = count_cur + CLS_BITS'(1);
                best_next  = best_new;
                bcls_next  = bcls_new;
            end
        end
    end

    // The pending pixel commits its class to the presence memory as it moves on.
    // Background never needs a mark since it never raises the flag.
    assign mem_we = p_move && (p_cls_reg != '0);

    // The memory returns old data when the read hits the entry committed at the same
    // edge, so that case is caught here and carried with the pixel.
    assign fwd_hit = mem_we && (p_cls_reg == bcls_new) && (p_epoch_reg == epoch_item);

    segam_ram #(
        .WIDTH (EPOCH_BITS),
        .DEPTH (MAX_CLASSES)
    ) u_seen_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (p_cls_reg),
        .wdata (p_epoch_reg),
        .re    (accept && pixel_last),
        .raddr (bcls_new),
        .rdata (mem_rdata)
    );

    // A class counts as seen in this frame when its tag is valid and matches the
    // pixel's epoch, or when the previous pixel just marked it.
    assign p_seen = p_fwd_reg || (seen_valid_reg[p_cls_reg] && (mem_rdata == p_epoch_reg));
    assign p_flag = (p_cls_reg != '0) && !p_seen;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class_count_reg <= CLASS_COUNT_RESET;
            count_reg       <= '0;
            best_reg        <= '0;
            bcls_reg        <= '0;
            epoch_reg       <= '0;
            p_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                class_count_reg <= cfg_data;
            end
            count_reg <= count_next;
            best_reg  <= best_next;
            bcls_reg  <= bcls_next;
            if (accept) begin
                epoch_reg <= epoch_item;
            end
            if (accept && pixel_last) begin
                p_valid_reg <= 1'b1;
            end else if (p_move) begin
                p_valid_reg <= 1'b0;
            end
            if (p_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // When the epoch wraps, every stored tag becomes ambiguous, so all valid bits go.
    // A commit at the same edge belongs to the old frame and is dropped with them.
    always_ff @(posedge aclk) begin
        if (!aresetn || epoch_wrap) begin
            seen_valid_reg <= '0;
        end else if (mem_we) begin
            seen_valid_reg[p_cls_reg] <= 1'b1;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (accept && pixel_last) begin
            p_cls_reg   <= bcls_new;
            p_epoch_reg <= epoch_item;
            p_fwd_reg   <= fwd_hit;
        end
        if (p_move) begin
            out_word_reg.mask_class <= CLASS_FIELD_BITS'(p_cls_reg);
            out_word_reg.first_seen <= p_flag;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

`default_nettype wire

// ===== dv/segmentation_argmax_mask_core_test.sv =====
// Self-checking testbench for the segmentation argmax mask core: directed table, then random phases.
// Depends on segam_pkg and the core RTL; drives the score, result and cfg_ channels directly.
`timescale 1ns / 100ps

module segmentation_argmax_mask_core_test
    import segam_pkg::*;
;

    localparam int MAX_CLASSES  = 256;
    localparam int DRAIN_CYCLES = 4;      // covers the pending lookup stage and output register, with some margin
    localparam int SCORE_MAX    = 16'hFFFF;

    typedef enum logic {
        ROW_SCORE,
        ROW_CFG
    } row_kind_t;

    // One line of the directed table. A row with has_want carries its expected
    // result typed in; every other row is checked against the argmax predictor.
    typedef struct {
        row_kind_t         kind;
        logic [15:0]       score;
        logic              frame_start;
        logic [CFG_BITS-1:0] count;
        bit                has_want;
        out_word_t         want;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_word_t            s_data;
    logic                m_valid;
    logic                m_ready;
    out_word_t           m_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_BITS-1:0] cfg_data;

    // Predictor state: the pixel accumulator, the class count register and the
    // set of classes other than 0 that have won a pixel since the last frame start.
    logic [CFG_BITS-1:0] class_count_reg;
    logic [7:0]          pix_chan;
    logic [15:0]         pix_best_score;
    logic [7:0]          pix_best_class;
    logic [255:0]        class_won;

    out_word_t exp_q[$];          // expected result words, oldest first
    dir_row_t  dir_rows[$];

    int          err_count;
    int          sender_idle_pct;
    int          recv_stall_pct;
    logic [15:0] last_score;

    always #10 aclk = ~aclk;

    segmentation_argmax_mask_core #(
        .MAX_CLASSES (MAX_CLASSES),
        .SCORE_BITS  (16)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Advance the pixel accumulator by one score word. Returns 1 and fills res
    // when the word closes a pixel. A class count of zero acts as one, and any
    // count above MAX_CLASSES saturates there.
    function automatic bit argmax_step(input logic [15:0] sc, input logic fs,
                                       output out_word_t res);
        int eff;
        eff = int'(class_count_reg);
        if (eff == 0) begin
            eff = 1;
        end
        if (eff > MAX_CLASSES) begin
            eff = MAX_CLASSES;
        end
        res = '0;
        // A frame start forgets the seen classes and restarts the pixel, so
        // this score becomes channel 0 no matter where the pixel stood.
        if (fs) begin
            class_won      = '0;
            pix_chan       = '0;
            pix_best_score = '0;
            pix_best_class = '0;
        end
        // Strictly greater only: ties keep the lower class index.
        if (sc > pix_best_score) begin
            pix_best_score = sc;
            pix_best_class = pix_chan;
        end
        // When the count was lowered mid-pixel the channel count may already be
        // at or past the new last channel; the pixel then closes right here.
        if (int'(pix_chan) + 1 < eff) begin
            pix_chan = pix_chan + 8'd1;
            return 1'b0;
        end
        res.mask_class = pix_best_class;
        res.first_seen = (pix_best_class != 8'd0) && !class_won[pix_best_class];
        if (res.first_seen) begin
            class_won[pix_best_class] = 1'b1;
        end
        pix_chan       = '0;
        pix_best_score = '0;
        pix_best_class = '0;
        return 1'b1;
    endfunction

    // Present one score word, starting at a falling edge, and hold it until the
    // core accepts it. Returns at the following falling edge with s_valid still
    // high, so back-to-back words keep valid asserted without a gap.
    task automatic push_score(input logic [15:0] sc, input logic fs,
                              input bit has_want, input out_word_t want);
        out_word_t res;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = '{score: sc, frame_start: fs};
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (argmax_step(sc, fs, res)) begin
            exp_q.push_back(has_want ? want : res);
        end
        last_score = sc;
        @(negedge aclk);
    endtask

    // Write the class count only once the core has gone quiet: every expected
    // word delivered, then a DRAIN_CYCLES wait for a pixel that may still be in flight.
    task automatic write_class_count(input logic [CFG_BITS-1:0] value);
        s_valid = 1'b0;
        while (exp_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        class_count_reg = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic add_score(input logic [15:0] sc, input logic fs);
        dir_rows.push_back('{ROW_SCORE, sc, fs, '0, 1'b0, '0});
    endtask

    task automatic add_check(input logic [15:0] sc, input logic fs,
                             input logic [7:0] cls, input logic flag);
        dir_rows.push_back('{ROW_SCORE, sc, fs, '0, 1'b1, '{mask_class: cls, first_seen: flag}});
    endtask

    task automatic add_cfg(input logic [CFG_BITS-1:0] value);
        dir_rows.push_back('{ROW_CFG, '0, 1'b0, value, 1'b0, '0});
    endtask

    // Random scores lean toward the values that matter for an argmax: zero,
    // full scale, ties with the previous word, and tiny values.
    function automatic logic [15:0] pick_score();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return SCORE_MAX[15:0];
            2:       return last_score;
            3:       return 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver side: m_ready moves only at falling edges.
    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready = !($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checker: every accepted word is compared with the oldest expectation.
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_q.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("unexpected result word: class %0d first_seen %0b",
                             m_data.mask_class, m_data.first_seen);
                end
            end else begin
                want = exp_q.pop_front();
                if (m_data.mask_class !== want.mask_class ||
                    m_data.first_seen !== want.first_seen) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("mismatch: class exp %0d got %0d, first_seen exp %0b got %0b",
                                 want.mask_class, m_data.mask_class,
                                 want.first_seen, m_data.first_seen);
                    end
                end
            end
        end
    end

    // Hard stop in case the core hangs on a handshake.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        // Random phases: class count, sender idle percent, receiver stall percent,
        // and the number of score words. Most counts are not whole pixels, so most
        // phases end mid-pixel and the next write moves the last channel under it.
        int ph_count[14];
        int ph_idle[14];
        int ph_stall[14];
        int ph_words[14];
        dir_row_t row;
        logic fs;

        ph_count = '{2, 3, 5, 1, 21, 4, 0, 8, 256, 7, 511, 257, 2, 3};
        ph_idle  = '{0, 81, 0, 24, 0, 81, 0, 24, 0, 0, 24, 81, 24, 0};
        ph_stall = '{0, 0, 81, 24, 0, 0, 81, 24, 0, 81, 24, 0, 24, 0};
        ph_words = '{41, 40, 52, 30, 60, 42, 30, 50, 150, 40, 150, 40, 31, 31};

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        err_count       = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        last_score      = '0;

        // Predictor starts from the reset state of the core.
        class_count_reg = CLASS_COUNT_RESET;
        pix_chan        = '0;
        pix_best_score  = '0;
        pix_best_class  = '0;
        class_won       = '0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table. Two classes per pixel keeps most cases to two words.
        add_cfg(9'd2);
        add_score(16'd0, 1'b1);
        add_check(16'd0, 1'b0, 8'd0, 1'b0);          // all-zero pixel is background
        add_score(16'd5, 1'b0);
        add_check(16'd5, 1'b0, 8'd0, 1'b0);          // tie keeps the lower class
        add_score(16'd0, 1'b0);
        add_check(16'hFFFF, 1'b0, 8'd1, 1'b1);       // class 1 wins for the first time
        add_score(16'hFFFF, 1'b0);
        add_check(16'hFFFF, 1'b0, 8'd0, 1'b0);       // full-scale tie
        add_score(16'd1, 1'b0);
        add_check(16'd2, 1'b0, 8'd1, 1'b0);          // class 1 already seen this frame
        add_score(16'd7, 1'b1);
        add_check(16'd9, 1'b0, 8'd1, 1'b1);          // frame start forgot class 1
        add_score(16'd3, 1'b0);
        add_cfg(9'd1);                               // count lowered under a started pixel
        add_score(16'd2, 1'b0);
        add_cfg(9'd0);                               // zero count acts as one
        add_check(16'd1, 1'b0, 8'd0, 1'b0);
        add_cfg(9'd3);
        add_score(16'd0, 1'b0);
        add_score(16'd0, 1'b0);
        add_check(16'hABCD, 1'b0, 8'd2, 1'b1);
        add_score(16'd10, 1'b0);
        add_score(16'h8000, 1'b1);                   // frame start in mid-pixel
        add_score(16'd1, 1'b0);
        add_check(16'h8001, 1'b0, 8'd2, 1'b1);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                write_class_count(row.count);
            end else begin
                push_score(row.score, row.frame_start, row.has_want, row.want);
            end
        end

        // Random part: mostly well-formed pixels with an occasional frame start at
        // a pixel boundary, plus a little noise in the form of frame starts that
        // cut a pixel short.
        for (int p = 0; p < 14; p++) begin
            write_class_count(ph_count[p][CFG_BITS-1:0]);
            sender_idle_pct = ph_idle[p];
            recv_stall_pct  = ph_stall[p];
            for (int w = 0; w < ph_words[p]; w++) begin
                if (pix_chan == 8'd0) begin
                    fs = ($urandom_range(7) == 0);
                end else begin
                    fs = ($urandom_range(39) == 0);
                end
                push_score(pick_score(), fs, 1'b0, '0);
            end
        end

        // Let everything drain, then allow for anything the core still emits.
        s_valid = 1'b0;
        while (exp_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES * 2) @(posedge aclk);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
